// File: sv/mqrf_pkg.sv
package mqrf_pkg;

  // Capacity registers on the configuration port
  localparam int CAP_REGS  = 4;
  localparam int CAP_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int READ_W    = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  // Outcome of one decoded word, carried while the store read is in flight
  typedef struct packed {
    status_t status;
    logic    rd_op;
  } result_t;

endpackage

// File: sv/mqrf_in_if.sv
interface mqrf_in_if #(
  parameter int WORD_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [2:0]            queue_number;
  logic [WORD_WIDTH-1:0] push_word;

  modport source (output valid, output opcode, output queue_number, output push_word,
                  input ready);
  modport sink   (input valid, input opcode, input queue_number, input push_word,
                  output ready);
endinterface

// File: sv/mqrf_out_if.sv
interface mqrf_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [mqrf_pkg::READ_W-1:0] read_word;

  modport source (output valid, output status, output read_word, input ready);
  modport sink   (input valid, input status, input read_word, output ready);
endinterface

// File: sv/mqrf_store.sv
module mqrf_store #(
  parameter int WORD_WIDTH = 32,
  parameter int ENTRIES    = 64
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [$clog2(ENTRIES)-1:0]  addr,
  input  logic [WORD_WIDTH-1:0]       wdata,
  output logic [WORD_WIDTH-1:0]       rdata
);

  logic [WORD_WIDTH-1:0] mem [ENTRIES];

  // Single port: write on push, registered read on pop or peek
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: sv/mqrf_ctrl.sv
module mqrf_ctrl #(
  parameter int QUEUE_COUNT = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                                             clk,
  input  logic                                             rst,
  // configuration
  input  logic                                             psel,
  input  logic                                             penable,
  input  logic                                             pwrite,
  input  logic [mqrf_pkg::PADDR_W-1:0]                     paddr,
  input  logic [mqrf_pkg::PDATA_W-1:0]                     pwdata,
  output logic [mqrf_pkg::PDATA_W-1:0]                     prdata,
  // decoded word
  input  logic                                             accept,
  input  logic [1:0]                                       opcode,
  input  logic [2:0]                                       queue_number,
  input  logic [WORD_WIDTH-1:0]                            push_word,
  output mqrf_pkg::result_t                                result,
  // store access
  output logic                                             mem_we,
  output logic                                             mem_re,
  output logic [$clog2(QUEUE_COUNT*QUEUE_DEPTH)-1:0]       mem_addr,
  output logic [WORD_WIDTH-1:0]                            mem_wdata
);

  localparam int QW     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int AW     = $clog2(QUEUE_COUNT * QUEUE_DEPTH);

  logic [mqrf_pkg::CAP_W-1:0] cap_reg [mqrf_pkg::CAP_REGS];
  logic [PTR_W-1:0]           wp      [QUEUE_COUNT];
  logic [PTR_W-1:0]           rp      [QUEUE_COUNT];
  logic [CNT_W-1:0]           fill    [QUEUE_COUNT];
  logic [CNT_W-1:0]           eff_cap [QUEUE_COUNT];

  logic [mqrf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                           cfg_we;
  logic [QW-1:0]                  qi;
  logic                           in_range;
  logic [CNT_W-1:0]               cap_sel;
  logic [CNT_W-1:0]               fill_sel;
  logic [PTR_W-1:0]               wp_sel;
  logic [PTR_W-1:0]               rp_sel;
  logic [PTR_W-1:0]               wp_next;
  logic [PTR_W-1:0]               rp_next;
  logic                           do_push;
  logic                           do_pop;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] p1;
    p1 = CNT_W'(p) + 1'b1;
    return (p1 >= cap) ? '0 : PTR_W'(p1);
  endfunction

  assign cfg_idx = paddr[mqrf_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = mqrf_pkg::PDATA_W'(cap_reg[cfg_idx]);

  // Clamp each capacity to the queue region; queues without a register stay unset
  for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_cap
    if (g < mqrf_pkg::CAP_REGS) begin : g_reg
      assign eff_cap[g] = (int'(cap_reg[g]) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH)
                                                            : CNT_W'(cap_reg[g]);
    end else begin : g_none
      assign eff_cap[g] = '0;
    end
  end

  // Decode the word against the addressed queue's pointer set
  always_comb begin
    qi       = QW'(queue_number);
    in_range = (int'(queue_number) < QUEUE_COUNT);
    cap_sel  = in_range ? eff_cap[qi] : '0;
    fill_sel = fill[qi];
    wp_sel   = wp[qi];
    rp_sel   = rp[qi];
    wp_next  = advance(wp_sel, cap_sel);
    rp_next  = advance(rp_sel, cap_sel);
    result   = '{status: mqrf_pkg::ST_ERROR, rd_op: 1'b0};
    do_push  = 1'b0;
    do_pop   = 1'b0;
    mem_addr = AW'(int'(qi) * QUEUE_DEPTH + int'(rp_sel));
    if (in_range && cap_sel != '0) begin
      case (opcode)
        mqrf_pkg::OP_PUSH: begin
          mem_addr = AW'(int'(qi) * QUEUE_DEPTH + int'(wp_sel));
          if (fill_sel >= cap_sel) begin
            result.status = mqrf_pkg::ST_FULL;
          end else begin
            result.status = mqrf_pkg::ST_OK;
            do_push       = 1'b1;
          end
        end
        mqrf_pkg::OP_POP, mqrf_pkg::OP_PEEK: begin
          if (fill_sel == '0) begin
            result.status = mqrf_pkg::ST_EMPTY;
          end else begin
            result.status = mqrf_pkg::ST_OK;
            result.rd_op  = 1'b1;
            do_pop        = (opcode == mqrf_pkg::OP_POP);
          end
        end
        default: begin
          result.status = mqrf_pkg::ST_ERROR;
        end
      endcase
    end
    mem_we    = accept && do_push;
    mem_re    = accept && result.rd_op;
    mem_wdata = push_word;
  end

  // Update pointers and counts; a capacity write empties its queue
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mqrf_pkg::CAP_REGS; i++) begin
        cap_reg[i] <= '0;
      end
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        wp[i]   <= '0;
        rp[i]   <= '0;
        fill[i] <= '0;
      end
    end else if (cfg_we) begin
      cap_reg[cfg_idx] <= pwdata[mqrf_pkg::CAP_W-1:0];
      if (int'(cfg_idx) < QUEUE_COUNT) begin
        wp[QW'(cfg_idx)]   <= '0;
        rp[QW'(cfg_idx)]   <= '0;
        fill[QW'(cfg_idx)] <= '0;
      end
    end else if (accept) begin
      if (do_push) begin
        wp[qi]   <= wp_next;
        fill[qi] <= fill_sel + 1'b1;
      end
      if (do_pop) begin
        rp[qi]   <= rp_next;
        fill[qi] <= fill_sel - 1'b1;
      end
    end
  end

  // A queue never holds more words than its capacity
  for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      fill[g] <= eff_cap[g])
      else $error("queue fill count above capacity");
  end

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store written and read in the same cycle");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    mem_we && !cfg_we |=> fill[$past(qi)] == CNT_W'($past(fill_sel) + 1'b1))
    else $error("accepted push did not grow the fill count");

endmodule

// File: sv/multi_queue_ring_fifo.sv
// Multi-queue ring FIFO: several circular queues share one word store.
//
// Request channel (request): opcode (push, pop, peek), queue_number and
// push_word. Response channel (response): status (ok, full, empty, error) and
// read_word, which holds the oldest word on an ok pop or peek and zero
// otherwise. Each request word yields exactly one response word, in order.
//
// The store is read in the acceptance cycle, and its registered data joins
// the status in the output register on the way to response valid. One
// request is taken per cycle while responses drain; the single-port store and
// the per-queue pointer registers set that rate.
// When response.ready is low the output register holds, one more word waits
// in the read stage, and then request.ready drops until the output moves.
//
// Capacities are written over the APB port (queue i at byte address 4*i);
// a write empties that queue. Reset clears all capacities, pointers and
// counts, so every queue answers error until its capacity is set. The
// store itself is not cleared; no pop or peek can reach an unwritten entry.
module multi_queue_ring_fifo #(
  parameter int QUEUE_COUNT = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  mqrf_in_if.sink                      request,
  mqrf_out_if.source                   response,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mqrf_pkg::PADDR_W-1:0] paddr,
  input  logic [mqrf_pkg::PDATA_W-1:0] pwdata,
  output logic [mqrf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int AW = $clog2(QUEUE_COUNT * QUEUE_DEPTH);

  logic                  accept;
  mqrf_pkg::result_t     result;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [WORD_WIDTH-1:0] mem_rdata;

  logic                  s1_valid;
  mqrf_pkg::result_t     s1_result;
  logic                  s1_advance;

  logic                          out_valid;
  mqrf_pkg::status_t             out_status;
  logic [mqrf_pkg::READ_W-1:0]   out_word;

  assign pready        = 1'b1;
  assign s1_advance    = s1_valid && (!out_valid || response.ready);
  assign request.ready = !s1_valid || s1_advance;
  assign accept        = request.valid && request.ready;

  mqrf_ctrl #(
    .QUEUE_COUNT (QUEUE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .accept       (accept),
    .opcode       (request.opcode),
    .queue_number (request.queue_number),
    .push_word    (request.push_word),
    .result       (result),
    .mem_we       (mem_we),
    .mem_re       (mem_re),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata)
  );

  mqrf_store #(
    .WORD_WIDTH (WORD_WIDTH),
    .ENTRIES    (QUEUE_COUNT * QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Read stage: hold the status while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_result <= result;
    end
  end

  // Output register: load from the read stage, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_status <= s1_result.status;
      out_word   <= s1_result.rd_op ? mqrf_pkg::READ_W'(mem_rdata) : '0;
    end
  end

  assign response.valid     = out_valid;
  assign response.status    = out_status;
  assign response.read_word = out_word;

  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != mqrf_pkg::ST_OK |-> out_word == '0)
    else $error("nonzero read word on a failed request");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !response.ready |=> s1_valid && $stable(s1_result))
    else $error("read stage lost a word while output stalled");

  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> s1_valid && out_valid)
    else $error("request stalled with room in the pipeline");

endmodule
